@@ hw/rtl/sct_pkg.sv @@
// Shared types and constants for the sine/cosine Taylor series evaluator
`default_nettype none
package sct_pkg;

	localparam int MAG_W   = 32;
	localparam int SQ_W    = 34;
	localparam int TERM_W  = 34;
	localparam int SUM_W   = 37;
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = 30;
	localparam int RCP_W   = 34;
	localparam int DIV_W   = 9;
	localparam int MAX_K   = 9;
	localparam int TURN_W  = 36;

	localparam logic [TURN_W-1:0] TWO_PI_Q32 = 36'd26986075409;
	localparam logic [TURN_W-1:0] PI_Q32     = 36'd13493037705;

	localparam logic [TERM_W-1:0] ONE_Q30  = 34'h0_4000_0000;
	localparam logic [63:0]       HALF_Q30 = 64'h0000_0000_2000_0000;
	localparam logic [63:0]       RCP_ONE  = 64'h0000_0004_0000_0000;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 37'sh00_7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 37'sh1F_8000_0000;

	localparam logic [DIV_W-1:0] DIV_SIN [MAX_K] = '{
		9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342
	};
	localparam logic [DIV_W-1:0] DIV_COS [MAX_K] = '{
		9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306
	};

	localparam logic [RCP_W-1:0] RCP_SIN [MAX_K] = '{
		RCP_W'(RCP_ONE / 6),   RCP_W'(RCP_ONE / 20),  RCP_W'(RCP_ONE / 42),
		RCP_W'(RCP_ONE / 72),  RCP_W'(RCP_ONE / 110), RCP_W'(RCP_ONE / 156),
		RCP_W'(RCP_ONE / 210), RCP_W'(RCP_ONE / 272), RCP_W'(RCP_ONE / 342)
	};
	localparam logic [RCP_W-1:0] RCP_COS [MAX_K] = '{
		RCP_W'(RCP_ONE / 2),   RCP_W'(RCP_ONE / 12),  RCP_W'(RCP_ONE / 30),
		RCP_W'(RCP_ONE / 56),  RCP_W'(RCP_ONE / 90),  RCP_W'(RCP_ONE / 132),
		RCP_W'(RCP_ONE / 182), RCP_W'(RCP_ONE / 240), RCP_W'(RCP_ONE / 306)
	};

	typedef struct packed {
		logic             valid;
		logic             func;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} item_t;

endpackage
`default_nettype wire

@@ hw/rtl/sct_reduce.sv @@
// Angle reduction pipeline: strip whole turns, fold into [-pi, pi], round to Q30 magnitude
`default_nettype none
module sct_reduce #(
	parameter int ANGLE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_func,
	input  wire logic [ANGLE_WIDTH-1:0] in_angle,
	output sct_pkg::item_t              out_item
);

	localparam int MW = ANGLE_WIDTH + 8;
	localparam int RW = (MW > sct_pkg::TURN_W) ? MW : sct_pkg::TURN_W;
	localparam int QB = (ANGLE_WIDTH > 27) ? ANGLE_WIDTH - 27 : 1;
	localparam logic [RW-1:0] TWO_PI   = RW'(sct_pkg::TWO_PI_Q32);
	localparam logic [RW-1:0] PI       = RW'(sct_pkg::PI_Q32);
	localparam logic [RW-1:0] NEG_FOLD = TWO_PI - PI;

	logic                   v_s1;
	logic                   func_s1;
	logic                   neg_s1;
	logic [ANGLE_WIDTH-1:0] mag_s1;

	logic          div_v_s    [QB+1];
	logic          div_func_s [QB+1];
	logic          div_neg_s  [QB+1];
	logic [RW-1:0] div_rem_s  [QB+1];

	logic [RW-1:0] rem_end;
	logic [RW-1:0] fold_m;
	logic [RW-1:0] fold_sum;
	logic          fold_neg;

	logic                      v_sf;
	logic                      func_sf;
	logic                      neg_sf;
	logic [sct_pkg::MAG_W-1:0] mag_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= in_func;
		neg_s1  <= in_angle[ANGLE_WIDTH-1];
		mag_s1  <= in_angle[ANGLE_WIDTH-1] ? (~in_angle + 1'b1) : in_angle;
	end

	always_comb begin
		div_v_s[0]    = v_s1;
		div_func_s[0] = func_s1;
		div_neg_s[0]  = neg_s1;
		div_rem_s[0]  = RW'(mag_s1) << 8;
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam logic [RW-1:0] STEP = TWO_PI << (QB - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j+1] <= 1'b0;
			end else begin
				div_v_s[j+1] <= div_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			div_func_s[j+1] <= div_func_s[j];
			div_neg_s[j+1]  <= div_neg_s[j];
			div_rem_s[j+1]  <= (div_rem_s[j] >= STEP) ? div_rem_s[j] - STEP : div_rem_s[j];
		end
	end

	always_comb begin
		rem_end = div_rem_s[QB];
		if (div_neg_s[QB]) begin
			if (rem_end < NEG_FOLD) begin
				fold_m   = rem_end;
				fold_neg = 1'b1;
			end else begin
				fold_m   = TWO_PI - rem_end;
				fold_neg = 1'b0;
			end
		end else if (rem_end > PI) begin
			fold_m   = TWO_PI - rem_end;
			fold_neg = 1'b1;
		end else begin
			fold_m   = rem_end;
			fold_neg = 1'b0;
		end
		fold_sum = fold_m + RW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else begin
			v_sf <= div_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		func_sf <= div_func_s[QB];
		neg_sf  <= fold_neg;
		mag_sf  <= fold_sum[sct_pkg::MAG_W+1:2];
	end

	always_comb begin
		out_item.valid = v_sf;
		out_item.func  = func_sf;
		out_item.neg   = neg_sf;
		out_item.mag   = mag_sf;
	end

endmodule
`default_nettype wire

@@ hw/rtl/sct_square_div.sv @@
// Square of the reduced angle and the per-term ratios x^2 / d_k by reciprocal multiply
`default_nettype none
module sct_square_div #(
	parameter int NUM_TERMS = 7
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire sct_pkg::item_t           in_item,
	output sct_pkg::item_t                out_item,
	output logic [sct_pkg::SQ_W-1:0]      ratio [NUM_TERMS-1]
);

	localparam int NK = NUM_TERMS - 1;
	localparam int PW = 2 * sct_pkg::MAG_W;
	localparam int QW = 2 * sct_pkg::SQ_W;
	localparam int SW = sct_pkg::SQ_W;

	logic          v_s1, func_s1, neg_s1;
	logic [sct_pkg::MAG_W-1:0] mag_s1;
	logic [PW-1:0] sqp_s1;

	logic          v_s2, func_s2, neg_s2;
	logic [sct_pkg::MAG_W-1:0] mag_s2;
	logic [SW-1:0] sq_s2;
	logic [PW:0]   sq_sum;

	logic          v_s3, func_s3, neg_s3;
	logic [sct_pkg::MAG_W-1:0] mag_s3;
	logic [SW-1:0] n_s3    [NK];
	logic [QW-1:0] prod_s3 [NK];

	logic          v_s4, func_s4, neg_s4;
	logic [sct_pkg::MAG_W-1:0] mag_s4;
	logic [SW-1:0] ratio_s4 [NK];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign sq_sum = {1'b0, sqp_s1} + (PW+1)'(sct_pkg::HALF_Q30);

	always_ff @(posedge clk) begin
		func_s1 <= in_item.func;
		neg_s1  <= in_item.neg;
		mag_s1  <= in_item.mag;
		sqp_s1  <= PW'(in_item.mag) * PW'(in_item.mag);
		func_s2 <= func_s1;
		neg_s2  <= neg_s1;
		mag_s2  <= mag_s1;
		sq_s2   <= sq_sum[sct_pkg::FRAC_W+SW-1:sct_pkg::FRAC_W];
		func_s3 <= func_s2;
		neg_s3  <= neg_s2;
		mag_s3  <= mag_s2;
		func_s4 <= func_s3;
		neg_s4  <= neg_s3;
		mag_s4  <= mag_s3;
	end

	for (genvar k = 0; k < NK; k++) begin : g_ratio
		logic [sct_pkg::DIV_W-1:0] d_in, d_out;
		logic [sct_pkg::RCP_W-1:0] rcp_in;
		logic [SW-1:0]             n_in;
		logic [SW-1:0]             q0;
		logic [SW-1:0]             qd;
		logic [SW-1:0]             rem;

		always_comb begin
			d_in   = func_s2 ? sct_pkg::DIV_COS[k] : sct_pkg::DIV_SIN[k];
			rcp_in = func_s2 ? sct_pkg::RCP_COS[k] : sct_pkg::RCP_SIN[k];
			n_in   = sq_s2 + SW'(d_in >> 1);
			d_out  = func_s3 ? sct_pkg::DIV_COS[k] : sct_pkg::DIV_SIN[k];
			q0     = prod_s3[k][QW-1:sct_pkg::RCP_W];
			qd     = SW'(q0 * SW'(d_out));
			rem    = n_s3[k] - qd;
		end

		always_ff @(posedge clk) begin
			n_s3[k]     <= n_in;
			prod_s3[k]  <= QW'(n_in) * QW'(rcp_in);
			ratio_s4[k] <= (rem >= SW'(d_out)) ? q0 + 1'b1 : q0;
		end
	end

	always_comb begin
		out_item.valid = v_s4;
		out_item.func  = func_s4;
		out_item.neg   = neg_s4;
		out_item.mag   = mag_s4;
		ratio          = ratio_s4;
	end

endmodule
`default_nettype wire

@@ hw/rtl/sct_series.sv @@
// Term chain of the Taylor series: multiply, round and accumulate, then sign and saturate
`default_nettype none
module sct_series #(
	parameter int NUM_TERMS = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sct_pkg::item_t              in_item,
	input  wire logic [sct_pkg::SQ_W-1:0]    ratio [NUM_TERMS-1],
	output logic                             done,
	output logic [sct_pkg::VALUE_W-1:0]      value
);

	localparam int NK = NUM_TERMS - 1;
	localparam int TW = sct_pkg::TERM_W;
	localparam int PW = 2 * sct_pkg::TERM_W;
	localparam int SW = sct_pkg::SUM_W;

	logic                 v_s    [NUM_TERMS];
	logic                 func_s [NUM_TERMS];
	logic                 neg_s  [NUM_TERMS];
	logic [TW-1:0]        t_s    [NUM_TERMS];
	logic signed [SW-1:0] sum_s  [NUM_TERMS];
	logic [sct_pkg::SQ_W-1:0] r_s [NUM_TERMS][NK];

	logic signed [SW-1:0]         fin;
	logic                         done_q;
	logic [sct_pkg::VALUE_W-1:0]  value_q;

	always_comb begin
		v_s[0]    = in_item.valid;
		func_s[0] = in_item.func;
		neg_s[0]  = in_item.neg;
		t_s[0]    = in_item.func ? sct_pkg::ONE_Q30 : TW'(in_item.mag);
		sum_s[0]  = signed'(SW'(t_s[0]));
		r_s[0]    = ratio;
	end

	for (genvar k = 1; k < NUM_TERMS; k++) begin : g_term
		logic                     v_s1, func_s1, neg_s1;
		logic [PW-1:0]            prod_s1;
		logic signed [SW-1:0]     sum_s1;
		logic [sct_pkg::SQ_W-1:0] r_s1 [NK];
		logic [PW-1:0]            rnd;
		logic [TW-1:0]            t_new;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1   <= 1'b0;
				v_s[k] <= 1'b0;
			end else begin
				v_s1   <= v_s[k-1];
				v_s[k] <= v_s1;
			end
		end

		always_comb begin
			rnd   = prod_s1 + PW'(sct_pkg::HALF_Q30);
			t_new = rnd[sct_pkg::FRAC_W+TW-1:sct_pkg::FRAC_W];
		end

		always_ff @(posedge clk) begin
			func_s1   <= func_s[k-1];
			neg_s1    <= neg_s[k-1];
			prod_s1   <= PW'(t_s[k-1]) * PW'(r_s[k-1][k-1]);
			sum_s1    <= sum_s[k-1];
			r_s1      <= r_s[k-1];
			func_s[k] <= func_s1;
			neg_s[k]  <= neg_s1;
			t_s[k]    <= t_new;
			r_s[k]    <= r_s1;
			if (k % 2 == 1) begin
				sum_s[k] <= sum_s1 - signed'(SW'(t_new));
			end else begin
				sum_s[k] <= sum_s1 + signed'(SW'(t_new));
			end
		end
	end

	always_comb begin
		fin = (!func_s[NK] && neg_s[NK]) ? -sum_s[NK] : sum_s[NK];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[NK];
		end
	end

	always_ff @(posedge clk) begin
		if (fin > sct_pkg::SUM_MAX) begin
			value_q <= sct_pkg::SUM_MAX[sct_pkg::VALUE_W-1:0];
		end else if (fin < sct_pkg::SUM_MIN) begin
			value_q <= sct_pkg::SUM_MIN[sct_pkg::VALUE_W-1:0];
		end else begin
			value_q <= fin[sct_pkg::VALUE_W-1:0];
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule
`default_nettype wire

@@ hw/rtl/sine_cosine_taylor_evaluator_core.sv @@
// Top level of the pipelined sine/cosine Taylor series evaluator
//
//   channel   transfer when        fields
//   input     start && !busy       func, angle (Q8.24)
//   result    done                 value (Q2.30, saturated)
//
// One item enters per cycle while busy is low, and the reduction uses
// QB = max(ANGLE_WIDTH-27, 1) turn-removal steps.
// The turn-removal compare/subtract steps and the two-stage term multiplies set the depth.
// busy is high during reset and the first cycle after it, low from then on.
// Results appear on done for one cycle each; nothing stalls the pipeline.
`default_nettype none
module sine_cosine_taylor_evaluator_core #(
	parameter int NUM_TERMS   = 7,
	parameter int ANGLE_WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               func,
	input  wire logic signed [ANGLE_WIDTH-1:0]      angle,
	output logic                                    done,
	output logic signed [sct_pkg::VALUE_W-1:0]      value
);

	logic                        busy_q;
	sct_pkg::item_t              red_item;
	sct_pkg::item_t              sq_item;
	logic [sct_pkg::SQ_W-1:0]    ratio [NUM_TERMS-1];
	logic [sct_pkg::VALUE_W-1:0] value_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	sct_reduce #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy_q),
		.in_func  (func),
		.in_angle (angle),
		.out_item (red_item)
	);

	sct_square_div #(
		.NUM_TERMS(NUM_TERMS)
	) u_square_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (red_item),
		.out_item (sq_item),
		.ratio    (ratio)
	);

	sct_series #(
		.NUM_TERMS(NUM_TERMS)
	) u_series (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (sq_item),
		.ratio   (ratio),
		.done    (done),
		.value   (value_raw)
	);

	assign value = signed'(value_raw);

endmodule
`default_nettype wire

@@ hw/rtl/sct_checker.sv @@
// Port-level checks for the sine/cosine Taylor series evaluator, bound to the top level
`default_nettype none
module sct_checker #(
	parameter int NUM_TERMS   = 7,
	parameter int ANGLE_WIDTH = 32
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          func,
	input wire logic [ANGLE_WIDTH-1:0]        angle,
	input wire logic                          done,
	input wire logic [sct_pkg::VALUE_W-1:0]   value
);

	localparam int QB  = (ANGLE_WIDTH > 27) ? ANGLE_WIDTH - 27 : 1;
	localparam int LAT = QB + 2 * NUM_TERMS + 5;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item produced no result");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted item");

	a_cos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func && angle == '0) |-> ##LAT (value == 32'h4000_0000))
		else $error("cosine of zero is not one");

	a_sin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !func && angle == '0) |-> ##LAT (value == 32'h0000_0000))
		else $error("sine of zero is not zero");

	a_busy_drops: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

endmodule

bind sine_cosine_taylor_evaluator_core sct_checker #(
	.NUM_TERMS   (NUM_TERMS),
	.ANGLE_WIDTH (ANGLE_WIDTH)
) u_sct_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.angle  (angle),
	.done   (done),
	.value  (value)
);
`default_nettype wire
